// File: hw/rtl/i2cte_pkg.sv
// ----------------------------------------------------------------------------
// i2cte_pkg
// Shared types and constants of the I2C target bit engine: command codes
// passed from the line front end to the execution unit, bus phases, event
// codes and configuration register indexes.
// ----------------------------------------------------------------------------
package i2cte_pkg;

	// input operation codes
	localparam logic OP_LINE_TICK = 1'b0;
	localparam logic OP_LOAD      = 1'b1;

	// configuration register indexes
	localparam logic CFG_OWN_ADDRESS = 1'b0;
	localparam logic CFG_ACK_ENABLE  = 1'b1;

	localparam int ADDR_W  = 7;
	localparam int BYTE_W  = 8;
	localparam int SLOT_W  = 4;
	localparam int QUEUE_W = 2;

	localparam logic [SLOT_W-1:0] SLOT_FIRST = 4'd0;
	localparam logic [SLOT_W-1:0] SLOT_LAST  = 4'd8;
	localparam logic [SLOT_W-1:0] SLOT_MSB   = 4'd7;
	localparam logic [BYTE_W-1:0] BIT7_MASK  = 8'h80;
	// latched address after reset: inverse of a zero own address
	localparam logic [BYTE_W-1:0] LATCH_RESET = 8'hFF;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_LOAD,
		CMD_START,
		CMD_STOP,
		CMD_FALL
	} cmd_kind_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ADDR,
		PH_RECV,
		PH_SEND
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_RX_BYTE,
		EV_WRITE_END,
		EV_READ_REQ
	} event_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic              sda;
		logic [BYTE_W-1:0] load_byte;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] own_address;
		logic              ack_enable;
	} cfg_t;

endpackage

// File: hw/rtl/i2cte_if.sv
// ----------------------------------------------------------------------------
// i2cte_if
// Valid/ready channels of the I2C target bit engine: the request channel
// (line samples and transmit loads) and the response channel.
// ----------------------------------------------------------------------------
interface i2cte_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic       sda_level;
	logic       scl_level;
	logic [7:0] load_byte;

	modport source (output valid, output operation, output sda_level,
		output scl_level, output load_byte, input ready);
	modport sink (input valid, input operation, input sda_level,
		input scl_level, input load_byte, output ready);
endinterface

interface i2cte_out_if;
	logic       valid;
	logic       ready;
	logic       sda_pull_low;
	logic [1:0] event_kind;
	logic [7:0] rx_data;
	logic       fifo_overflow;

	modport source (output valid, output sda_pull_low, output event_kind,
		output rx_data, output fifo_overflow, input ready);
	modport sink (input valid, input sda_pull_low, input event_kind,
		input rx_data, input fifo_overflow, output ready);
endinterface

// File: hw/rtl/i2c_target_bit_engine_unit.sv
// ----------------------------------------------------------------------------
// i2c_target_bit_engine_unit
// Seven-bit I2C target engine driven by sampled SDA/SCL levels and transmit
// byte loads.
// ----------------------------------------------------------------------------
// Every request item (a line sample or a transmit load) gives exactly one
// response item with the current SDA drive, an event code, the received byte
// and the overflow flag. The unit takes one item per clock when the response
// side keeps up: the front end classifies the line sample against the
// previous levels, a two-entry queue decouples it from the execution unit,
// and the execution unit retires one command per cycle into an output
// register. A request is registered in the queue entry and its response in
// the output register; the queue does not pass a command straight through.
// The transmit FIFO is a TX_DEPTH x 8 memory whose head
// entry is read ahead into a register, so a byte pop needs no separate read.
// Reset needs no clearing pass. The user must write configuration only while
// no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module i2c_target_bit_engine_unit #(
	parameter int TX_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	i2cte_in_if.sink                     req,
	i2cte_out_if.source                  rsp,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [i2cte_pkg::ADDR_W-1:0] cfg_wdata
);

	i2cte_pkg::cfg_t cfg;
	i2cte_pkg::cmd_t push_cmd;
	i2cte_pkg::cmd_t pop_cmd;
	logic            push_valid;
	logic            push_ready;
	logic            pop_valid;
	logic            pop_ready;

	i2cte_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	i2cte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	i2cte_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd),
		.pop_ready  (pop_ready)
	);

	i2cte_back #(
		.TX_DEPTH (TX_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (pop_valid),
		.cmd       (pop_cmd),
		.cmd_ready (pop_ready),
		.rsp       (rsp)
	);

endmodule

// File: hw/rtl/i2cte_front.sv
// ----------------------------------------------------------------------------
// i2cte_front
// Accepts request items, tracks the previous line levels and classifies each
// item as a load, START, STOP, SCL fall or no-op command.
// ----------------------------------------------------------------------------
module i2cte_front (
	input  logic              clk,
	input  logic              arst_n,
	i2cte_in_if.sink          req,
	output logic              push_valid,
	output i2cte_pkg::cmd_t   push_cmd,
	input  logic              push_ready
);

	logic prev_sda_q;
	logic prev_scl_q;
	logic sda_changed;
	logic scl_fell;
	logic accept;

	assign req.ready  = push_ready;
	assign push_valid = req.valid;
	assign accept     = req.valid & push_ready;

	assign sda_changed = req.sda_level != prev_sda_q;
	assign scl_fell    = prev_scl_q & ~req.scl_level;

	always_comb begin
		push_cmd.sda       = req.sda_level;
		push_cmd.load_byte = req.load_byte;
		if (req.operation == i2cte_pkg::OP_LOAD) begin
			push_cmd.kind = i2cte_pkg::CMD_LOAD;
		end else if (req.scl_level && sda_changed && !req.sda_level) begin
			push_cmd.kind = i2cte_pkg::CMD_START;
		end else if (req.scl_level && sda_changed) begin
			push_cmd.kind = i2cte_pkg::CMD_STOP;
		end else if (scl_fell) begin
			push_cmd.kind = i2cte_pkg::CMD_FALL;
		end else begin
			push_cmd.kind = i2cte_pkg::CMD_NOP;
		end
	end

	// loads leave the edge history alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sda_q <= 1'b1;
			prev_scl_q <= 1'b1;
		end else if (accept && req.operation == i2cte_pkg::OP_LINE_TICK) begin
			prev_sda_q <= req.sda_level;
			prev_scl_q <= req.scl_level;
		end
	end

endmodule

// File: hw/rtl/i2cte_cmd_queue.sv
// ----------------------------------------------------------------------------
// i2cte_cmd_queue
// Two-entry command queue between the front end and the execution unit.
// ----------------------------------------------------------------------------
module i2cte_cmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  i2cte_pkg::cmd_t   push_cmd,
	output logic              push_ready,
	output logic              pop_valid,
	output i2cte_pkg::cmd_t   pop_cmd,
	input  logic              pop_ready
);

	i2cte_pkg::cmd_t                 entry_q [2];
	logic                            wr_ptr_q;
	logic                            rd_ptr_q;
	logic [i2cte_pkg::QUEUE_W-1:0]   count_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/i2cte_back.sv
// ----------------------------------------------------------------------------
// i2cte_back
// Execution unit: runs one command per cycle while the response output is
// not stalled, against the bus phase, bit slot counter, shift registers and
// transmit FIFO, and registers the result.
module i2cte_back #(
	parameter int TX_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  i2cte_pkg::cfg_t   cfg,
	input  logic              cmd_valid,
	input  i2cte_pkg::cmd_t   cmd,
	output logic              cmd_ready,
	i2cte_out_if.source       rsp
);

	localparam int PTR_W = $clog2(TX_DEPTH);
	localparam int CNT_W = $clog2(TX_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(TX_DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(TX_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TX_DEPTH - 1);

	logic [i2cte_pkg::BYTE_W-1:0] mem [TX_DEPTH];
	logic [i2cte_pkg::BYTE_W-1:0] head_data_q;

	i2cte_pkg::phase_t             phase_q, phase_d;
	logic [i2cte_pkg::SLOT_W-1:0]  bit_q, bit_d;
	logic [i2cte_pkg::BYTE_W-1:0]  rx_q, rx_d;
	logic [i2cte_pkg::BYTE_W-1:0]  tx_q, tx_d;
	logic [i2cte_pkg::BYTE_W-1:0]  latched_q, latched_d;
	logic                          host_writing_q, host_writing_d;
	logic                          drive_q, drive_d;
	logic [CNT_W-1:0]              tx_count_q, tx_count_d;
	logic [PTR_W-1:0]              tx_head_q, tx_head_d;

	logic                          out_valid_q;
	logic                          out_drive_q;
	i2cte_pkg::event_t             out_event_q, ev;
	logic [i2cte_pkg::BYTE_W-1:0]  out_data_q, data;
	logic                          out_ovf_q, ovf;

	logic                          pop;
	logic                          mem_we;
	logic [SUM_W-1:0]              wr_sum;
	logic [PTR_W-1:0]              wr_addr;
	logic [i2cte_pkg::SLOT_W-1:0]  slot;
	logic [i2cte_pkg::BYTE_W-1:0]  rx_new;
	logic [PTR_W-1:0]              head_inc;

	assign cmd_ready = !out_valid_q || rsp.ready;
	assign pop       = cmd_valid && cmd_ready;

	// FIFO tail address: head plus fill count, wrapped once
	assign wr_sum  = SUM_W'(tx_head_q) + SUM_W'(tx_count_q);
	assign wr_addr = (wr_sum >= DEPTH_S) ? PTR_W'(wr_sum - DEPTH_S) : PTR_W'(wr_sum);
	assign head_inc = (tx_head_q == PTR_LAST) ? '0 : tx_head_q + 1'b1;

	// slot counts past the last act as the last
	assign slot   = (bit_q >= i2cte_pkg::SLOT_LAST) ? i2cte_pkg::SLOT_LAST : bit_q;
	assign rx_new = rx_q | (cmd.sda ? (i2cte_pkg::BIT7_MASK >> (slot - 4'd1))
		: '0);

	always_comb begin
		phase_d        = phase_q;
		bit_d          = bit_q;
		rx_d           = rx_q;
		tx_d           = tx_q;
		latched_d      = latched_q;
		host_writing_d = host_writing_q;
		drive_d        = drive_q;
		tx_count_d     = tx_count_q;
		tx_head_d      = tx_head_q;
		ev             = i2cte_pkg::EV_NONE;
		data           = '0;
		ovf            = 1'b0;
		mem_we         = 1'b0;
		if (pop) begin
			case (cmd.kind)
				i2cte_pkg::CMD_LOAD: begin
					if (tx_count_q < DEPTH_C) begin
						mem_we     = 1'b1;
						tx_count_d = tx_count_q + 1'b1;
					end else begin
						ovf = 1'b1;
					end
				end
				i2cte_pkg::CMD_START: begin
					phase_d        = i2cte_pkg::PH_ADDR;
					bit_d          = i2cte_pkg::SLOT_FIRST;
					rx_d           = '0;
					host_writing_d = 1'b1;
					drive_d        = 1'b0;
				end
				i2cte_pkg::CMD_STOP: begin
					if (host_writing_q && latched_q[7:1] == cfg.own_address) begin
						ev = i2cte_pkg::EV_WRITE_END;
					end
					phase_d        = i2cte_pkg::PH_IDLE;
					bit_d          = i2cte_pkg::SLOT_FIRST;
					rx_d           = '0;
					host_writing_d = 1'b1;
					latched_d      = ~{cfg.own_address, 1'b0};
					tx_count_d     = '0;
					tx_head_d      = '0;
					drive_d        = 1'b0;
				end
				i2cte_pkg::CMD_FALL: begin
					if (cfg.ack_enable) begin
						drive_d = 1'b0;
					end
					if (phase_q inside {i2cte_pkg::PH_ADDR, i2cte_pkg::PH_RECV}) begin
						if (bit_q == i2cte_pkg::SLOT_FIRST) begin
							bit_d = 4'd1;
						end else if (slot < i2cte_pkg::SLOT_LAST) begin
							rx_d  = rx_new;
							bit_d = bit_q + 4'd1;
						end else begin
							if (phase_q == i2cte_pkg::PH_ADDR) begin
								if (rx_new[7:1] == cfg.own_address) begin
									latched_d = rx_new;
									if (cfg.ack_enable) begin
										drive_d = 1'b1;
									end
									if (rx_new[0]) begin
										phase_d        = i2cte_pkg::PH_SEND;
										host_writing_d = 1'b0;
										ev             = i2cte_pkg::EV_READ_REQ;
									end else begin
										phase_d = i2cte_pkg::PH_RECV;
									end
								end else begin
									phase_d = i2cte_pkg::PH_IDLE;
								end
							end else begin
								if (cfg.ack_enable) begin
									drive_d = 1'b1;
								end
								ev   = i2cte_pkg::EV_RX_BYTE;
								data = rx_new;
							end
							bit_d = i2cte_pkg::SLOT_FIRST;
							rx_d  = '0;
						end
					end else if (phase_q == i2cte_pkg::PH_SEND) begin
						if (bit_q == i2cte_pkg::SLOT_FIRST) begin
							if (tx_count_q == '0) begin
								phase_d = i2cte_pkg::PH_IDLE;
								drive_d = 1'b0;
							end else begin
								tx_d       = head_data_q;
								tx_head_d  = head_inc;
								tx_count_d = tx_count_q - 1'b1;
								drive_d    = ~head_data_q[7];
								bit_d      = 4'd1;
							end
						end else if (slot < i2cte_pkg::SLOT_LAST) begin
							drive_d = ~tx_q[3'(i2cte_pkg::SLOT_MSB - bit_q)];
							bit_d   = bit_q + 4'd1;
						end else begin
							// release for the master's ack slot
							drive_d = 1'b0;
							bit_d   = i2cte_pkg::SLOT_FIRST;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// FIFO storage with a registered read of the next head entry
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= cmd.load_byte;
		end
		if (mem_we && wr_addr == tx_head_d) begin
			head_data_q <= cmd.load_byte;
		end else begin
			head_data_q <= mem[tx_head_d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= i2cte_pkg::PH_IDLE;
			bit_q          <= i2cte_pkg::SLOT_FIRST;
			rx_q           <= '0;
			tx_q           <= '0;
			latched_q      <= i2cte_pkg::LATCH_RESET;
			host_writing_q <= 1'b1;
			drive_q        <= 1'b0;
			tx_count_q     <= '0;
			tx_head_q      <= '0;
		end else begin
			phase_q        <= phase_d;
			bit_q          <= bit_d;
			rx_q           <= rx_d;
			tx_q           <= tx_d;
			latched_q      <= latched_d;
			host_writing_q <= host_writing_d;
			drive_q        <= drive_d;
			tx_count_q     <= tx_count_d;
			tx_head_q      <= tx_head_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_drive_q <= drive_d;
			out_event_q <= ev;
			out_data_q  <= data;
			out_ovf_q   <= ovf;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.sda_pull_low  = out_drive_q;
	assign rsp.event_kind    = out_event_q;
	assign rsp.rx_data       = out_data_q;
	assign rsp.fifo_overflow = out_ovf_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tx_count_q <= DEPTH_C)
		else $error("transmit FIFO count above depth");

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= i2cte_pkg::SLOT_LAST)
		else $error("bit slot counter out of range");

	a_stop_flush: assert property (@(posedge clk) disable iff (!arst_n)
		pop && cmd.kind == i2cte_pkg::CMD_STOP |=> tx_count_q == '0 && tx_head_q == '0)
		else $error("STOP did not empty the transmit FIFO");

	a_send_is_read: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == i2cte_pkg::PH_SEND |-> !host_writing_q)
		else $error("transmit phase during a master write");

	a_ovf_only_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop && ovf |-> cmd.kind == i2cte_pkg::CMD_LOAD && tx_count_q == DEPTH_C)
		else $error("overflow flagged without a load into a full FIFO");
`endif

endmodule

// File: hw/rtl/i2cte_cmd_queue_wrap_note.sv
// ----------------------------------------------------------------------------
// i2cte_cfg_regs
// Configuration registers of the I2C target bit engine: own address and
// acknowledge enable, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module i2cte_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [i2cte_pkg::ADDR_W-1:0]   cfg_wdata,
	output i2cte_pkg::cfg_t                cfg
);

	logic [i2cte_pkg::ADDR_W-1:0] own_address_q;
	logic                         ack_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
			ack_enable_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cte_pkg::CFG_OWN_ADDRESS: own_address_q <= cfg_wdata;
				i2cte_pkg::CFG_ACK_ENABLE:  ack_enable_q  <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.own_address = own_address_q;
	assign cfg.ack_enable  = ack_enable_q;

endmodule
